@@ src/glh_pkg.sv @@
// Shared types and constants for the grey-level histogram block.
// Depends on nothing; imported by every module of the block.
package glh_pkg;

	localparam int BinCount = 256;
	localparam int IdxW     = 8;
	localparam int CntW     = 17;
	localparam int OpW      = 2;

	localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

	// opcode encodings on the input stream
	localparam logic [OpW-1:0] OP_COUNT      = 2'd0;
	localparam logic [OpW-1:0] OP_READ       = 2'd1;
	localparam logic [OpW-1:0] OP_READ_CLEAR = 2'd2;

	// stream tdata widths (fields packed from bit 0, padded to bytes)
	localparam int InDataW  = 16;
	localparam int OutDataW = 32;

	// classified command passed from front to back
	typedef struct packed {
		logic [OpW-1:0]  op;
		logic [IdxW-1:0] idx;
	} cmd_t;

	// queue status seen by the front and the top level
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ src/glh_front.sv @@
// Front end: accepts input requests, decodes the opcode and drops unused codes.
// Depends on glh_pkg; feeds glh_queue.
module glh_front import glh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [InDataW-1:0]   s_tdata,   // [1:0] opcode, [9:2] pixel_value
	output logic                 cmd_vld,
	output cmd_t                 cmd,
	input  logic                 q_ready
);

	logic            cmd_vld_q;
	cmd_t            cmd_q;
	logic [OpW-1:0]  in_op;
	logic [IdxW-1:0] in_idx;
	logic            op_ok;

	assign in_op  = s_tdata[OpW-1:0];
	assign in_idx = s_tdata[OpW+IdxW-1:OpW];

	// decode: only the three defined opcodes go on to the back end
	assign op_ok = in_op inside {OP_COUNT, OP_READ, OP_READ_CLEAR};

	assign s_tready = !cmd_vld_q || q_ready;
	assign cmd_vld  = cmd_vld_q;
	assign cmd      = cmd_q;

	// holding register for one decoded request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			cmd_vld_q <= op_ok;
		end else if (q_ready) begin
			cmd_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q.op  <= in_op;
			cmd_q.idx <= in_idx;
		end
	end

endmodule

@@ src/glh_queue.sv @@
// Small FIFO of decoded commands between the front and back ends.
// Depends on glh_pkg; DEPTH comes from the top level.
module glh_queue import glh_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntQW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0]  PTR_LAST = PtrW'(DEPTH - 1);
	localparam logic [CntQW-1:0] CNT_FULL = CntQW'(DEPTH);

	cmd_t             entry_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntQW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ src/glh_back.sv @@
// Back end: bin memory, read-modify-write with forwarding, result register.
// Depends on glh_pkg; fed by glh_queue.
module glh_back import glh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_vld,
	input  cmd_t                q_cmd,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata   // [7:0] bin_index, [24:8] bin_count
);

	logic [CntW-1:0] mem [BinCount];
	logic [BinCount-1:0] bin_vld_q;

	logic            vld_s1;
	cmd_t            cmd_s1;
	logic [CntW-1:0] rd_data_s1;
	logic            rd_vld_s1;

	logic            fwd_vld_q;
	logic [IdxW-1:0] fwd_idx_q;
	logic [CntW-1:0] fwd_val_q;

	logic            out_vld_q;
	logic [IdxW-1:0] out_idx_q;
	logic [CntW-1:0] out_cnt_q;

	logic            needs_out;
	logic            retire;
	logic            load;
	logic            wr_en;
	logic [CntW-1:0] cur;
	logic [CntW-1:0] nxt;

	// current bin value: last write wins over the registered memory read
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == cmd_s1.idx) begin
			cur = fwd_val_q;
		end else if (rd_vld_s1) begin
			cur = rd_data_s1;
		end else begin
			cur = '0;
		end
	end

	// update value per opcode
	always_comb begin
		case (cmd_s1.op)
			OP_COUNT:      nxt = (cur == CNT_MAX) ? cur : cur + 1'b1;
			OP_READ_CLEAR: nxt = '0;
			default:       nxt = cur;
		endcase
	end

	assign needs_out = (cmd_s1.op != OP_COUNT);
	assign retire    = vld_s1 && (!needs_out || !out_vld_q || m_tready);
	assign load      = q_vld && (!vld_s1 || retire);
	assign q_pop     = load;
	assign wr_en     = retire && (cmd_s1.op != OP_READ);

	// stage control and write forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
			bin_vld_q <= '0;
		end else begin
			if (load) begin
				vld_s1 <= 1'b1;
			end else if (retire) begin
				vld_s1 <= 1'b0;
			end
			if (wr_en) begin
				fwd_vld_q            <= 1'b1;
				bin_vld_q[cmd_s1.idx] <= 1'b1;
			end
		end
	end

	// memory port and stage payload
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd_s1.idx] <= nxt;
			fwd_idx_q       <= cmd_s1.idx;
			fwd_val_q       <= nxt;
		end
		if (load) begin
			cmd_s1     <= q_cmd;
			rd_data_s1 <= mem[q_cmd.idx];
			rd_vld_s1  <= bin_vld_q[q_cmd.idx];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (retire && needs_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && needs_out) begin
			out_idx_q <= cmd_s1.idx;
			out_cnt_q <= cur;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OutDataW - CntW - IdxW){1'b0}}, out_cnt_q, out_idx_q};

endmodule

@@ src/grey_level_histogram_core.sv @@
// Grey-level histogram, 256 bins of 17-bit saturating counts.
// Path from an accepted request to its result: front register, queue, bin
// read stage, result register. Throughput: one request per cycle when the
// result output does not stall, set by the read-modify-write of the bin
// memory (one read and one write port) with forwarding of the last write.
// Reset (arst_n low) clears all bins via per-bin valid flags; no clearing pass.
module grey_level_histogram_core import glh_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,   // [1:0] opcode, [9:2] pixel_value
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata    // [7:0] bin_index, [24:8] bin_count
);

	logic    front_vld;
	cmd_t    front_cmd;
	cmd_t    q_head;
	q_stat_t q_stat;
	logic    q_pop;

	glh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.cmd_vld  (front_vld),
		.cmd      (front_cmd),
		.q_ready  (!q_stat.full)
	);

	glh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_vld),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	glh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_vld    (!q_stat.empty),
		.q_cmd    (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata)
	);

`ifndef SYNTH
	// queue cannot be full and empty at once
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// front keeps its request while the queue is full
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_vld && q_stat.full |=> front_vld)
		else $error("front dropped a request on a full queue");

	// result padding bits stay zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OutDataW-1:CntW+IdxW] == '0)
		else $error("result padding not zero");
`endif

endmodule
